// ===== hdl/assert_macros.svh =====
// Assertion helpers used by npps_back.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge out of reset.
`define NPPS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Expression must never be true out of reset.
`define NPPS_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) else $error(msg);
`else
`define NPPS_ASSERT(lbl, clk, rstn, prop, msg)
`define NPPS_NEVER(lbl, clk, rstn, expr, msg)
`endif

`endif

// ===== hdl/npps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package npps_pkg;

  localparam int MAX_JOBS = 16;
  localparam int IDX_W    = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CNT_W    = $clog2(MAX_JOBS + 1);
  localparam int ARR_W    = 16;
  localparam int BUR_W    = 16;
  localparam int PRI_W    = 10;
  localparam int TIME_W   = 21;
  localparam int ID_W     = 5;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [TIME_W-1:0] time_t;
  typedef logic [ID_W-1:0]   id_t;

  // Job record passed from the front end to the scheduler.
  typedef struct packed {
    logic [ARR_W-1:0] arrival;
    logic [BUR_W-1:0] burst;
    logic [PRI_W-1:0] prio;
    logic             keep;
    logic             last;
  } job_rec_t;

  // Candidate held during a selection scan.
  typedef struct packed {
    logic [PRI_W-1:0] prio;
    logic [ARR_W-1:0] arrival;
    logic [BUR_W-1:0] burst;
    idx_t             idx;
  } cand_t;

endpackage

`default_nettype wire

// ===== hdl/npps_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module npps_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [npps_pkg::ARR_W-1:0]  in_arrival_time,
  input  logic [npps_pkg::BUR_W-1:0]  in_burst_length,
  input  logic [npps_pkg::PRI_W-1:0]  in_priority_level,
  input  logic                        in_load_last,
  output logic                        push_valid,
  input  logic                        push_ready,
  output npps_pkg::job_rec_t          push_data
);

  npps_pkg::cnt_t cnt_r, cnt_nxt;
  logic           keep;
  logic           xfer;

  assign keep     = cnt_r < npps_pkg::cnt_t'(npps_pkg::MAX_JOBS);
  assign in_ready = push_ready;
  assign xfer     = in_valid && in_ready;

  // Drop jobs beyond capacity, but always forward the batch end.
  assign push_valid        = in_valid && (keep || in_load_last);
  assign push_data.arrival = in_arrival_time;
  assign push_data.burst   = in_burst_length;
  assign push_data.prio    = in_priority_level;
  assign push_data.keep    = keep;
  assign push_data.last    = in_load_last;

  always_comb begin
    cnt_nxt = cnt_r;
    if (xfer) begin
      if (in_load_last) begin
        cnt_nxt = '0;
      end else if (keep) begin
        cnt_nxt = cnt_r + npps_pkg::cnt_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/npps_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module npps_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_ready,
  input  npps_pkg::job_rec_t push_data,
  output logic               pop_valid,
  input  logic               pop_ready,
  output npps_pkg::job_rec_t pop_data
);

  npps_pkg::job_rec_t mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] fill_r;
  logic       push, pop;

  assign push_ready = fill_r != 2'd2;
  assign pop_valid  = fill_r != 2'd0;
  assign pop_data   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        fill_r <= fill_r + 2'd1;
      end else if (pop && !push) begin
        fill_r <= fill_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/npps_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module npps_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  output logic                         q_ready,
  input  npps_pkg::job_rec_t           q_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [npps_pkg::ID_W-1:0]    out_job_id,
  output logic [npps_pkg::TIME_W-1:0]  out_completion_time,
  output logic [npps_pkg::TIME_W-1:0]  out_turnaround_time,
  output logic [npps_pkg::TIME_W-1:0]  out_waiting_time,
  output logic                         out_run_last
);

  localparam logic [1:0] ST_FILL = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  // ahead: runs first among ready jobs (priority, arrival, burst)
  function automatic logic ahead(npps_pkg::cand_t a, npps_pkg::cand_t b);
    logic res;
    if (a.prio != b.prio) begin
      res = a.prio < b.prio;
    end else if (a.arrival != b.arrival) begin
      res = a.arrival < b.arrival;
    end else begin
      res = a.burst < b.burst;
    end
    return res;
  endfunction

  // earlier: first to run after an idle jump (arrival, then as ahead)
  function automatic logic earlier(npps_pkg::cand_t a, npps_pkg::cand_t b);
    logic res;
    if (a.arrival != b.arrival) begin
      res = a.arrival < b.arrival;
    end else if (a.prio != b.prio) begin
      res = a.prio < b.prio;
    end else begin
      res = a.burst < b.burst;
    end
    return res;
  endfunction

  logic [1:0]                    state_r;
  logic [npps_pkg::ARR_W-1:0]    arr_tbl_r [npps_pkg::MAX_JOBS];
  logic [npps_pkg::BUR_W-1:0]    bur_tbl_r [npps_pkg::MAX_JOBS];
  logic [npps_pkg::PRI_W-1:0]    pri_tbl_r [npps_pkg::MAX_JOBS];
  logic [npps_pkg::MAX_JOBS-1:0] fin_r;
  npps_pkg::cnt_t                fill_cnt_r, done_r;
  npps_pkg::idx_t                scan_i_r;
  npps_pkg::time_t               cur_r;
  npps_pkg::cand_t               rdy_r, early_r;
  logic                          rdy_vld_r, early_vld_r;
  logic                          out_valid_r;

  npps_pkg::cand_t ent, sel;
  npps_pkg::idx_t  fill_idx;
  npps_pkg::time_t start, comp, tat, wt;
  logic            ent_uf, ent_ready, take_rdy, take_early, scan_end;
  logic            out_free, emit, is_final, pop;

  assign fill_idx    = fill_cnt_r[npps_pkg::IDX_W-1:0];
  assign ent.prio    = pri_tbl_r[scan_i_r];
  assign ent.arrival = arr_tbl_r[scan_i_r];
  assign ent.burst   = bur_tbl_r[scan_i_r];
  assign ent.idx     = scan_i_r;

  assign ent_uf     = !fin_r[scan_i_r];
  assign ent_ready  = ent_uf && (npps_pkg::time_t'(ent.arrival) <= cur_r);
  assign take_rdy   = ent_ready && (!rdy_vld_r || ahead(ent, rdy_r));
  assign take_early = ent_uf && (!early_vld_r || earlier(ent, early_r));
  assign scan_end   = (npps_pkg::cnt_t'(scan_i_r) + npps_pkg::cnt_t'(1)) == fill_cnt_r;

  // No ready job: jump to the earliest pending arrival.
  assign sel   = rdy_vld_r ? rdy_r : early_r;
  assign start = rdy_vld_r ? cur_r : npps_pkg::time_t'(early_r.arrival);
  assign comp  = start + npps_pkg::time_t'(sel.burst);
  assign tat   = comp - npps_pkg::time_t'(sel.arrival);
  assign wt    = start - npps_pkg::time_t'(sel.arrival);

  assign out_free = !out_valid_r || out_ready;
  assign emit     = (state_r == ST_EMIT) && out_free;
  assign is_final = (done_r + npps_pkg::cnt_t'(1)) == fill_cnt_r;
  assign q_ready  = state_r == ST_FILL;
  assign pop      = q_valid && q_ready;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FILL;
      fill_cnt_r  <= '0;
      done_r      <= '0;
      scan_i_r    <= '0;
      cur_r       <= '0;
      fin_r       <= '0;
      rdy_vld_r   <= 1'b0;
      early_vld_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_FILL: begin
          if (pop) begin
            if (q_data.keep) begin
              fin_r[fill_idx] <= 1'b0;
              fill_cnt_r      <= fill_cnt_r + npps_pkg::cnt_t'(1);
            end
            if (q_data.last) begin
              state_r     <= ST_SCAN;
              scan_i_r    <= '0;
              done_r      <= '0;
              rdy_vld_r   <= 1'b0;
              early_vld_r <= 1'b0;
            end
          end
        end
        ST_SCAN: begin
          if (take_rdy) begin
            rdy_vld_r <= 1'b1;
          end
          if (take_early) begin
            early_vld_r <= 1'b1;
          end
          scan_i_r <= scan_i_r + npps_pkg::idx_t'(1);
          if (scan_end) begin
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            if (is_final) begin
              // Batch done: drop the schedule and wait for new loads.
              fill_cnt_r <= '0;
              cur_r      <= '0;
              fin_r      <= '0;
              state_r    <= ST_FILL;
            end else begin
              fin_r[sel.idx] <= 1'b1;
              cur_r          <= comp;
              done_r         <= done_r + npps_pkg::cnt_t'(1);
              scan_i_r       <= '0;
              rdy_vld_r      <= 1'b0;
              early_vld_r    <= 1'b0;
              state_r        <= ST_SCAN;
            end
          end
        end
        default: begin
          state_r <= ST_FILL;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop && q_data.keep) begin
      arr_tbl_r[fill_idx] <= q_data.arrival;
      bur_tbl_r[fill_idx] <= q_data.burst;
      pri_tbl_r[fill_idx] <= q_data.prio;
    end
    if ((state_r == ST_SCAN) && take_rdy) begin
      rdy_r <= ent;
    end
    if ((state_r == ST_SCAN) && take_early) begin
      early_r <= ent;
    end
    if (emit) begin
      out_job_id          <= npps_pkg::id_t'(sel.idx) + npps_pkg::id_t'(1);
      out_completion_time <= comp;
      out_turnaround_time <= tat;
      out_waiting_time    <= wt;
      out_run_last        <= is_final;
    end
  end

  `NPPS_ASSERT(a_emit_has_cand, clk, rst_n, (state_r == ST_EMIT) |-> (rdy_vld_r || early_vld_r), "issue without a candidate")
  `NPPS_ASSERT(a_fill_bound, clk, rst_n, fill_cnt_r <= npps_pkg::cnt_t'(npps_pkg::MAX_JOBS), "job table overfilled")
  `NPPS_ASSERT(a_scan_nonempty, clk, rst_n, (state_r == ST_SCAN) |-> (fill_cnt_r != '0), "scan over an empty table")
  `NPPS_ASSERT(a_issue_marks, clk, rst_n, (emit && !is_final) |=> fin_r[$past(sel.idx)], "issued job not marked finished")

endmodule

`default_nettype wire

// ===== hdl/nonpreemptive_priority_scheduler.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Non-preemptive priority scheduler.
// Input channel (in_valid/in_ready): one job per transfer with arrival time,
// burst length and priority level; in_load_last marks the final job of a batch.
// Up to 16 jobs are kept; further jobs of the batch are dropped.
// A two-entry queue parts the loader from the scheduler, so loads go on while
// the queue has room and the next batch may start loading while a schedule runs.
// After the final job, the scheduler issues one result per job in run order
// (out_valid/out_ready): job id, completion, turnaround and waiting time, with
// out_run_last on the final result of the batch.
// For each result the scheduler scans every stored job through the single
// job-table read port, then issues the selected job once the output is free.
// Reset clears the batch, the queue and the result valid flag; job table
// contents are only read once loaded.
// A stalled receiver holds the result register and the scheduler waits on it;
// loading continues until the queue is full.

module nonpreemptive_priority_scheduler (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [npps_pkg::ARR_W-1:0]   in_arrival_time,
  input  logic [npps_pkg::BUR_W-1:0]   in_burst_length,
  input  logic [npps_pkg::PRI_W-1:0]   in_priority_level,
  input  logic                         in_load_last,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [npps_pkg::ID_W-1:0]    out_job_id,
  output logic [npps_pkg::TIME_W-1:0]  out_completion_time,
  output logic [npps_pkg::TIME_W-1:0]  out_turnaround_time,
  output logic [npps_pkg::TIME_W-1:0]  out_waiting_time,
  output logic                         out_run_last
);

  logic               push_valid, push_ready;
  npps_pkg::job_rec_t push_data;
  logic               q_valid, q_ready;
  npps_pkg::job_rec_t q_data;

  npps_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_arrival_time   (in_arrival_time),
    .in_burst_length   (in_burst_length),
    .in_priority_level (in_priority_level),
    .in_load_last      (in_load_last),
    .push_valid        (push_valid),
    .push_ready        (push_ready),
    .push_data         (push_data)
  );

  npps_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  npps_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_valid             (q_valid),
    .q_ready             (q_ready),
    .q_data              (q_data),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_job_id          (out_job_id),
    .out_completion_time (out_completion_time),
    .out_turnaround_time (out_turnaround_time),
    .out_waiting_time    (out_waiting_time),
    .out_run_last        (out_run_last)
  );

endmodule

`default_nettype wire
